[hw/rtl/assert_macros.svh]
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define PPA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("ppa assertion failed");

// Clocked assertion that is also checked while reset is held.
`define PPA_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("ppa reset assertion failed");

`endif

[hw/rtl/ppa_pkg.sv]
`timescale 1ns / 1ps

package ppa_pkg;

    localparam int COORD_W     = 16;
    localparam int NUM_COORDS  = 8;
    localparam int S_TDATA_W   = COORD_W * NUM_COORDS;
    localparam int SIDE_W      = 17;
    localparam int PERIM_W     = 19;
    localparam int AREA_W      = 34;
    localparam int M_TDATA_W   = 56;
    localparam int PAD_W       = M_TDATA_W - PERIM_W - AREA_W;

    typedef logic signed [COORD_W-1:0] coord_t;

    // The four side lengths of one item, with its valid bit and shape selector.
    typedef struct packed {
        logic              valid;
        logic              action;
        logic [SIDE_W-1:0] s1;
        logic [SIDE_W-1:0] s2;
        logic [SIDE_W-1:0] s3;
        logic [SIDE_W-1:0] s4;
    } sides_t;

    typedef struct packed {
        logic               valid;
        logic [PERIM_W-1:0] perimeter;
        logic [AREA_W-1:0]  area;
    } result_t;

endpackage

[hw/rtl/polygon_perimeter_area.sv]
`timescale 1ns / 1ps

// Perimeter and area of a quadrilateral or a triangle from up to four vertices in signed
// fixed point with four fraction bits. A quadrilateral gives the sum of its four side
// lengths and, taken as a rectangle, side AB times side BC; a triangle gives its perimeter
// and Heron's area, the truncated square root of p(p-2a)(p-2b)(p-2c) divided by four, or
// zero where truncated sides make the triangle degenerate. Side lengths are truncated
// square roots, so results are in units of 1/16 for the perimeter and 1/256 for the area.
// The block takes one beat every clock cycle while no result waits on m_axis_tready; the
// pipeline length is set by the two digit-per-stage square root pipelines, 17 stages for
// the sides and 38 for the Heron product. The whole pipeline holds while a result waits on
// m_axis_tready, and nothing is lost or repeated across a stall.
module polygon_perimeter_area (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // ax, ay, bx, by_coord, cx, cy, dx, dy, 16 bits each, from the lowest bit up.
    input  logic [ppa_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // action: 0 quadrilateral, 1 triangle.
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // perimeter (19 bits), area (34 bits), then three zero bits.
    output logic [ppa_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
    import ppa_pkg::*;

    logic                  en;
    sides_t                sides;
    result_t               res;
    logic                  m_valid_reg;
    logic [M_TDATA_W-1:0]  m_data_reg;

    // Every stage moves together while the output register is free or being emptied.
    assign en            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    ppa_side u_side (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_action (s_axis_tuser),
        .ax        (s_axis_tdata[0*COORD_W +: COORD_W]),
        .ay        (s_axis_tdata[1*COORD_W +: COORD_W]),
        .bx        (s_axis_tdata[2*COORD_W +: COORD_W]),
        .by_coord  (s_axis_tdata[3*COORD_W +: COORD_W]),
        .cx        (s_axis_tdata[4*COORD_W +: COORD_W]),
        .cy        (s_axis_tdata[5*COORD_W +: COORD_W]),
        .dx        (s_axis_tdata[6*COORD_W +: COORD_W]),
        .dy        (s_axis_tdata[7*COORD_W +: COORD_W]),
        .sides     (sides)
    );

    ppa_heron u_heron (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .sides   (sides),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= {{PAD_W{1'b0}}, res.area, res.perimeter};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

[hw/rtl/ppa_side.sv]
`timescale 1ns / 1ps

module ppa_side (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  logic            in_action,
    input  ppa_pkg::coord_t ax,
    input  ppa_pkg::coord_t ay,
    input  ppa_pkg::coord_t bx,
    input  ppa_pkg::coord_t by_coord,
    input  ppa_pkg::coord_t cx,
    input  ppa_pkg::coord_t cy,
    input  ppa_pkg::coord_t dx,
    input  ppa_pkg::coord_t dy,
    output ppa_pkg::sides_t sides
);
    import ppa_pkg::*;

    localparam int NS         = 4;
    localparam int SQ_W       = 2 * COORD_W + 1;
    localparam int RAD_W      = 2 * SIDE_W;
    localparam int REM_W      = SIDE_W + 2;
    localparam int STEPS      = SIDE_W;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [SIDE_W-1:0] root;
    } sq_state_t;

    function automatic logic [COORD_W-1:0] abs_diff(coord_t a, coord_t b);
        logic [COORD_W:0] d;
        d = {b[COORD_W-1], b} - {a[COORD_W-1], a};
        return d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
    endfunction

    // One digit of a restoring square root: two radicand bits in, one root bit out.
    function automatic sq_state_t sq_step(sq_state_t x);
        sq_state_t        y;
        logic [REM_W-1:0] rem2;
        logic [REM_W-1:0] trial;
        rem2  = {x.rem[REM_W-3:0], x.rad[RAD_W-1 -: 2]};
        trial = {x.root, 2'b01};
        y.rad = {x.rad[RAD_W-3:0], 2'b00};
        if (rem2 >= trial) begin
            y.rem  = rem2 - trial;
            y.root = {x.root[SIDE_W-2:0], 1'b1};
        end else begin
            y.rem  = rem2;
            y.root = {x.root[SIDE_W-2:0], 1'b0};
        end
        return y;
    endfunction

    logic                 v0_reg;
    logic                 act0_reg;
    logic [COORD_W-1:0]   ux_reg [NS];
    logic [COORD_W-1:0]   uy_reg [NS];
    logic [COORD_W-1:0]   ux_next [NS];
    logic [COORD_W-1:0]   uy_next [NS];
    logic [SQ_W-1:0]      sq_next [NS];

    logic                 vs_reg  [0:STEPS];
    logic                 act_reg [0:STEPS];
    sq_state_t            st_reg  [0:STEPS][NS];

    always_comb begin
        ux_next[0] = abs_diff(ax, bx);
        uy_next[0] = abs_diff(ay, by_coord);
        ux_next[1] = abs_diff(bx, cx);
        uy_next[1] = abs_diff(by_coord, cy);
        // For a triangle, the third side closes back to the first vertex.
        ux_next[2] = abs_diff(cx, in_action ? ax : dx);
        uy_next[2] = abs_diff(cy, in_action ? ay : dy);
        ux_next[3] = abs_diff(dx, ax);
        uy_next[3] = abs_diff(dy, ay);
    end

    always_comb begin
        for (int k = 0; k < NS; k++) begin
            sq_next[k] = SQ_W'(ux_reg[k]) * SQ_W'(ux_reg[k]) +
                         SQ_W'(uy_reg[k]) * SQ_W'(uy_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            for (int j = 0; j <= STEPS; j++) begin
                vs_reg[j] <= 1'b0;
            end
        end else if (en) begin
            v0_reg    <= in_valid;
            vs_reg[0] <= v0_reg;
            for (int j = 1; j <= STEPS; j++) begin
                vs_reg[j] <= vs_reg[j-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            act0_reg   <= in_action;
            act_reg[0] <= act0_reg;
            for (int k = 0; k < NS; k++) begin
                ux_reg[k]         <= ux_next[k];
                uy_reg[k]         <= uy_next[k];
                st_reg[0][k].rad  <= RAD_W'(sq_next[k]);
                st_reg[0][k].rem  <= '0;
                st_reg[0][k].root <= '0;
            end
            for (int j = 1; j <= STEPS; j++) begin
                act_reg[j] <= act_reg[j-1];
                for (int k = 0; k < NS; k++) begin
                    st_reg[j][k] <= sq_step(st_reg[j-1][k]);
                end
            end
        end
    end

    assign sides.valid  = vs_reg[STEPS];
    assign sides.action = act_reg[STEPS];
    assign sides.s1     = st_reg[STEPS][0].root;
    assign sides.s2     = st_reg[STEPS][1].root;
    assign sides.s3     = st_reg[STEPS][2].root;
    assign sides.s4     = st_reg[STEPS][3].root;

endmodule

[hw/rtl/ppa_heron.sv]
`timescale 1ns / 1ps

module ppa_heron (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  ppa_pkg::sides_t  sides,
    output ppa_pkg::result_t res
);
    import ppa_pkg::*;

    localparam int F_W    = PERIM_W + 1;
    localparam int PROD_W = 2 * PERIM_W;
    localparam int HALF_W = PROD_W / 2;
    localparam int PART_W = PROD_W + HALF_W;
    localparam int RAD_W  = 2 * PROD_W;
    localparam int ROOT_W = PROD_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int STEPS  = ROOT_W;
    localparam int FIRST  = 3;
    localparam int LAST   = FIRST + STEPS;

    typedef struct packed {
        logic               act;
        logic               zero;
        logic [PERIM_W-1:0] per;
        logic [AREA_W-1:0]  qarea;
    } carry_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sq_state_t;

    function automatic sq_state_t sq_step(sq_state_t x);
        sq_state_t        y;
        logic [REM_W-1:0] rem2;
        logic [REM_W-1:0] trial;
        rem2  = {x.rem[REM_W-3:0], x.rad[RAD_W-1 -: 2]};
        trial = {x.root, 2'b01};
        y.rad = {x.rad[RAD_W-3:0], 2'b00};
        if (rem2 >= trial) begin
            y.rem  = rem2 - trial;
            y.root = {x.root[ROOT_W-2:0], 1'b1};
        end else begin
            y.rem  = rem2;
            y.root = {x.root[ROOT_W-2:0], 1'b0};
        end
        return y;
    endfunction

    function automatic logic [PERIM_W-1:0] mag(logic [F_W-1:0] f);
        return f[F_W-1] ? PERIM_W'(-f) : f[PERIM_W-1:0];
    endfunction

    logic                 v_reg   [0:LAST];
    carry_t               c_reg   [0:LAST];
    carry_t               c_next;

    logic [PERIM_W-1:0]   p_reg;
    logic [PERIM_W-1:0]   af1_reg, af2_reg, af3_reg;
    logic [PROD_W-1:0]    m1_reg, m2_reg;
    logic [PART_W-1:0]    pl_reg, ph_reg;
    sq_state_t            st_reg  [FIRST:LAST];

    logic [PERIM_W-1:0]   p_next, qper_next;
    logic [F_W-1:0]       f1, f2, f3;
    logic [AREA_W-1:0]    qa_next;

    always_comb begin
        p_next    = PERIM_W'(sides.s1) + PERIM_W'(sides.s2) + PERIM_W'(sides.s3);
        qper_next = p_next + PERIM_W'(sides.s4);
        qa_next   = sides.s1 * sides.s2;
        f1        = {1'b0, p_next} - {2'b00, sides.s1, 1'b0};
        f2        = {1'b0, p_next} - {2'b00, sides.s2, 1'b0};
        f3        = {1'b0, p_next} - {2'b00, sides.s3, 1'b0};
        c_next.act   = sides.action;
        c_next.per   = sides.action ? p_next : qper_next;
        c_next.qarea = qa_next;
        // Degenerate triangle, or a radicand made negative by side truncation.
        c_next.zero  = (f1 == '0) || (f2 == '0) || (f3 == '0) || (p_next == '0) ||
                       (f1[F_W-1] ^ f2[F_W-1] ^ f3[F_W-1]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j <= LAST; j++) begin
                v_reg[j] <= 1'b0;
            end
        end else if (en) begin
            v_reg[0] <= sides.valid;
            for (int j = 1; j <= LAST; j++) begin
                v_reg[j] <= v_reg[j-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg[0] <= c_next;
            for (int j = 1; j <= LAST; j++) begin
                c_reg[j] <= c_reg[j-1];
            end
            p_reg   <= p_next;
            af1_reg <= mag(f1);
            af2_reg <= mag(f2);
            af3_reg <= mag(f3);
            m1_reg  <= p_reg * af1_reg;
            m2_reg  <= af2_reg * af3_reg;
            pl_reg  <= m1_reg * m2_reg[HALF_W-1:0];
            ph_reg  <= m1_reg * m2_reg[PROD_W-1:HALF_W];
            st_reg[FIRST].rad  <= RAD_W'(pl_reg) + (RAD_W'(ph_reg) << HALF_W);
            st_reg[FIRST].rem  <= '0;
            st_reg[FIRST].root <= '0;
            for (int j = FIRST + 1; j <= LAST; j++) begin
                st_reg[j] <= sq_step(st_reg[j-1]);
            end
        end
    end

    assign res.valid     = v_reg[LAST];
    assign res.perimeter = c_reg[LAST].per;
    assign res.area      = !c_reg[LAST].act ? c_reg[LAST].qarea :
                           c_reg[LAST].zero ? '0 : st_reg[LAST].root[AREA_W+1:2];

endmodule

[hw/rtl/ppa_check_sva.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ppa_check_sva (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [ppa_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic                            s_axis_tuser,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [ppa_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
    import ppa_pkg::*;

    `PPA_ASSERT(a_hold_valid, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    `PPA_ASSERT(a_hold_data, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    `PPA_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready)
    `PPA_ASSERT(a_pad_zero, m_axis_tvalid |-> m_axis_tdata[M_TDATA_W-1:M_TDATA_W-PAD_W] == '0)
    `PPA_ASSERT_RST(a_reset_idle, !aresetn |=> !m_axis_tvalid)

endmodule

bind polygon_perimeter_area ppa_check_sva u_ppa_check_sva (.*);
